@@ rtl/core/ppg_pkg.sv @@
// shared types and constants of the perspective point to grid cell block
package ppg_pkg;

   localparam int GRID_ROWS = 4;
   localparam int GRID_COLS = 10;

   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 4;
   localparam int COEF_W    = 32;
   localparam int POS_W     = 12;
   localparam int IDX_W     = 8;
   localparam int PROD_W    = COEF_W + POS_W;
   localparam int NUM_W     = PROD_W + 2;
   localparam int MAG_W     = NUM_W;
   localparam int QUO_W     = IDX_W;
   localparam int DEN_SH_W  = MAG_W + QUO_W - 1;
   localparam int DIV_STEPS = QUO_W;

   // 1.0 in Q8.24
   localparam int ONE_Q24   = 1 << 24;

   localparam int NEG_LIMIT = 1 << (IDX_W - 1);
   localparam int POS_LIMIT = NEG_LIMIT - 1;

   typedef logic signed [COEF_W-1:0] coef_word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [DEN_SH_W-1:0]      den_sh_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic [QUO_W:0]           quo_up_type;
   typedef logic signed [IDX_W-1:0]  index_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COL_COEF_X = 4'd0,
      REG_COL_COEF_Y = 4'd1,
      REG_COL_OFFSET = 4'd2,
      REG_ROW_COEF_X = 4'd3,
      REG_ROW_COEF_Y = 4'd4,
      REG_ROW_OFFSET = 4'd5,
      REG_DEN_COEF_X = 4'd6,
      REG_DEN_COEF_Y = 4'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
   } req_type;

   typedef struct packed {
      index_type row_index;
      index_type col_index;
      logic      in_grid;
      logic      zero_denominator;
   } rsp_type;

   typedef struct packed {
      coef_word_type col_coef_x;
      coef_word_type col_coef_y;
      coef_word_type col_offset;
      coef_word_type row_coef_x;
      coef_word_type row_coef_y;
      coef_word_type row_offset;
      coef_word_type den_coef_x;
      coef_word_type den_coef_y;
   } coef_type;

   typedef struct packed {
      num_type col_num;
      num_type row_num;
      num_type den_num;
   } sum_type;

   typedef struct packed {
      mag_type rem;
      quo_type quo;
      logic    neg;
      logic    sat;
   } lane_type;

   typedef struct packed {
      lane_type   col;
      lane_type   row;
      den_sh_type den_sh;
      logic       zero;
   } div_type;

endpackage

@@ rtl/core/ppg_mac.sv @@
// products and sums of the two numerators and the denominator, two stages
module ppg_mac (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  ppg_pkg::req_type  in_data,
   input  ppg_pkg::coef_type coef,
   output logic              out_valid,
   output ppg_pkg::sum_type  out_sum
);

   logic s1_valid_ff;
   logic s2_valid_ff;

   ppg_pkg::prod_type p_cx_ff, p_cy_ff, p_rx_ff, p_ry_ff, p_dx_ff, p_dy_ff;
   ppg_pkg::prod_type p_cx_in, p_cy_in, p_rx_in, p_ry_in, p_dx_in, p_dy_in;
   ppg_pkg::sum_type  sum_ff;
   ppg_pkg::sum_type  sum_in;

   always_comb begin
      p_cx_in = ppg_pkg::prod_type'(coef.col_coef_x) * ppg_pkg::prod_type'(in_data.pos_x);
      p_cy_in = ppg_pkg::prod_type'(coef.col_coef_y) * ppg_pkg::prod_type'(in_data.pos_y);
      p_rx_in = ppg_pkg::prod_type'(coef.row_coef_x) * ppg_pkg::prod_type'(in_data.pos_x);
      p_ry_in = ppg_pkg::prod_type'(coef.row_coef_y) * ppg_pkg::prod_type'(in_data.pos_y);
      p_dx_in = ppg_pkg::prod_type'(coef.den_coef_x) * ppg_pkg::prod_type'(in_data.pos_x);
      p_dy_in = ppg_pkg::prod_type'(coef.den_coef_y) * ppg_pkg::prod_type'(in_data.pos_y);
   end

   always_comb begin
      sum_in.col_num = ppg_pkg::num_type'(p_cx_ff) + ppg_pkg::num_type'(p_cy_ff)
                     + ppg_pkg::num_type'(coef.col_offset);
      sum_in.row_num = ppg_pkg::num_type'(p_rx_ff) + ppg_pkg::num_type'(p_ry_ff)
                     + ppg_pkg::num_type'(coef.row_offset);
      sum_in.den_num = ppg_pkg::num_type'(p_dx_ff) + ppg_pkg::num_type'(p_dy_ff)
                     + ppg_pkg::num_type'(ppg_pkg::ONE_Q24);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_cx_ff <= p_cx_in;
         p_cy_ff <= p_cy_in;
         p_rx_ff <= p_rx_in;
         p_ry_ff <= p_ry_in;
         p_dx_ff <= p_dx_in;
         p_dy_ff <= p_dy_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_sum   = sum_ff;

endmodule

@@ rtl/core/ppg_prep.sv @@
// magnitudes, signs, zero and saturation detect ahead of the divider, two stages
module ppg_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  ppg_pkg::sum_type in_sum,
   output logic             out_valid,
   output ppg_pkg::div_type out_item
);

   logic             s3_valid_ff;
   logic             s4_valid_ff;
   ppg_pkg::mag_type col_mag_ff, row_mag_ff, den_mag_ff;
   ppg_pkg::mag_type col_mag_in, row_mag_in, den_mag_in;
   logic             col_neg_ff, row_neg_ff, zero_ff;
   logic             col_neg_in, row_neg_in, zero_in;
   ppg_pkg::div_type item_ff;
   ppg_pkg::div_type item_in;

   function automatic ppg_pkg::mag_type magnitude(ppg_pkg::num_type v);
      ppg_pkg::num_type n;
      n = -v;
      return v[ppg_pkg::NUM_W-1] ? ppg_pkg::mag_type'(n) : ppg_pkg::mag_type'(v);
   endfunction

   // quotient of 2^QUO_W or more always saturates
   function automatic logic too_big(ppg_pkg::mag_type num, ppg_pkg::mag_type den);
      return {{ppg_pkg::QUO_W{1'b0}}, num} >= {den, {ppg_pkg::QUO_W{1'b0}}};
   endfunction

   always_comb begin
      col_mag_in = magnitude(in_sum.col_num);
      row_mag_in = magnitude(in_sum.row_num);
      den_mag_in = magnitude(in_sum.den_num);
      col_neg_in = in_sum.col_num[ppg_pkg::NUM_W-1] ^ in_sum.den_num[ppg_pkg::NUM_W-1];
      row_neg_in = in_sum.row_num[ppg_pkg::NUM_W-1] ^ in_sum.den_num[ppg_pkg::NUM_W-1];
      zero_in    = (in_sum.den_num == '0);
   end

   always_comb begin
      item_in.col.rem = col_mag_ff;
      item_in.col.quo = '0;
      item_in.col.neg = col_neg_ff;
      item_in.col.sat = too_big(col_mag_ff, den_mag_ff);
      item_in.row.rem = row_mag_ff;
      item_in.row.quo = '0;
      item_in.row.neg = row_neg_ff;
      item_in.row.sat = too_big(row_mag_ff, den_mag_ff);
      item_in.den_sh  = {den_mag_ff, {(ppg_pkg::QUO_W-1){1'b0}}};
      item_in.zero    = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         col_mag_ff <= col_mag_in;
         row_mag_ff <= row_mag_in;
         den_mag_ff <= den_mag_in;
         col_neg_ff <= col_neg_in;
         row_neg_ff <= row_neg_in;
         zero_ff    <= zero_in;
         item_ff    <= item_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/core/ppg_div_step.sv @@
// one restoring division step for both lanes, one quotient bit each
module ppg_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  ppg_pkg::div_type in_item,
   output logic             out_valid,
   output ppg_pkg::div_type out_item
);

   logic             valid_ff;
   ppg_pkg::div_type item_ff;
   ppg_pkg::div_type item_in;

   function automatic ppg_pkg::lane_type step_lane(ppg_pkg::lane_type l,
                                                   ppg_pkg::den_sh_type d);
      ppg_pkg::lane_type   r;
      ppg_pkg::den_sh_type wide;
      logic                hit;
      r    = l;
      wide = ppg_pkg::den_sh_type'(l.rem);
      hit  = (wide >= d);
      if (hit) begin
         r.rem = ppg_pkg::mag_type'(wide - d);
      end
      r.quo = {l.quo[ppg_pkg::QUO_W-2:0], hit};
      return r;
   endfunction

   always_comb begin
      item_in        = in_item;
      item_in.col    = step_lane(in_item.col, in_item.den_sh);
      item_in.row    = step_lane(in_item.row, in_item.den_sh);
      item_in.den_sh = in_item.den_sh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/core/perspective_point_to_grid_cell.sv @@
// top level: coefficient registers, mapping pipeline and result register
//
//  port group  dir  handshake              payload
//  req_        in   req_valid / req_stall  req_data  (pos_x, pos_y)
//  rsp_        out  rsp_valid / rsp_stall  rsp_data  (row_index, col_index, in_grid,
//                                                     zero_denominator)
//  csr_        in   csr_valid / csr_ready  csr_index, csr_data
//
// one point per cycle while no result waits under rsp_stall; the stages are two multiply/add stages, two stages
// of magnitude and saturation detect, eight restoring division steps (one
// quotient bit each) and the result register.
// synchronous reset clears all valid bits and the coefficients to zero.
// the whole pipeline holds while a result waits under rsp_stall; req_stall
// follows that condition, so nothing in flight is lost or duplicated.
// csr_ready is always high; writes to indexes beyond the register list are dropped.
module perspective_point_to_grid_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ppg_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppg_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ppg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppg_pkg::COEF_W-1:0]       csr_data
);

   logic              advance;
   ppg_pkg::coef_type coef_ff;

   logic              sum_valid;
   ppg_pkg::sum_type  sum_item;
   logic              prep_valid;
   ppg_pkg::div_type  prep_item;

   logic              step_valid [ppg_pkg::DIV_STEPS+1];
   ppg_pkg::div_type  step_item  [ppg_pkg::DIV_STEPS+1];

   logic              rsp_valid_ff;
   ppg_pkg::rsp_type  rsp_data_ff;
   ppg_pkg::rsp_type  rsp_data_in;
   ppg_pkg::index_type row_in, col_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid) begin
         unique case (ppg_pkg::reg_idx_type'(csr_index))
            ppg_pkg::REG_COL_COEF_X: coef_ff.col_coef_x <= csr_data;
            ppg_pkg::REG_COL_COEF_Y: coef_ff.col_coef_y <= csr_data;
            ppg_pkg::REG_COL_OFFSET: coef_ff.col_offset <= csr_data;
            ppg_pkg::REG_ROW_COEF_X: coef_ff.row_coef_x <= csr_data;
            ppg_pkg::REG_ROW_COEF_Y: coef_ff.row_coef_y <= csr_data;
            ppg_pkg::REG_ROW_OFFSET: coef_ff.row_offset <= csr_data;
            ppg_pkg::REG_DEN_COEF_X: coef_ff.den_coef_x <= csr_data;
            ppg_pkg::REG_DEN_COEF_Y: coef_ff.den_coef_y <= csr_data;
            default: ;
         endcase
      end
   end

   ppg_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .coef      (coef_ff),
      .out_valid (sum_valid),
      .out_sum   (sum_item)
   );

   ppg_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sum_valid),
      .in_sum    (sum_item),
      .out_valid (prep_valid),
      .out_item  (prep_item)
   );

   assign step_valid[0] = prep_valid;
   assign step_item[0]  = prep_item;

   for (genvar k = 0; k < ppg_pkg::DIV_STEPS; k++) begin : g_div
      ppg_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (step_valid[k]),
         .in_item   (step_item[k]),
         .out_valid (step_valid[k+1]),
         .out_item  (step_item[k+1])
      );
   end

   // floor of the signed quotient, saturated to the index range
   function automatic ppg_pkg::index_type finish_lane(ppg_pkg::lane_type l);
      ppg_pkg::quo_up_type up;
      ppg_pkg::quo_up_type neg_up;
      ppg_pkg::index_type  r;
      up     = {1'b0, l.quo} + {{ppg_pkg::QUO_W{1'b0}}, (l.rem != '0)};
      neg_up = ~up + 1'b1;
      if (l.neg) begin
         if (l.sat || up > ppg_pkg::quo_up_type'(ppg_pkg::NEG_LIMIT)) begin
            r = {1'b1, {(ppg_pkg::IDX_W-1){1'b0}}};
         end else begin
            r = neg_up[ppg_pkg::IDX_W-1:0];
         end
      end else begin
         if (l.sat || l.quo > ppg_pkg::quo_type'(ppg_pkg::POS_LIMIT)) begin
            r = {1'b0, {(ppg_pkg::IDX_W-1){1'b1}}};
         end else begin
            r = l.quo[ppg_pkg::IDX_W-1:0];
         end
      end
      return r;
   endfunction

   always_comb begin
      row_in = finish_lane(step_item[ppg_pkg::DIV_STEPS].row);
      col_in = finish_lane(step_item[ppg_pkg::DIV_STEPS].col);
      rsp_data_in.zero_denominator = step_item[ppg_pkg::DIV_STEPS].zero;
      if (step_item[ppg_pkg::DIV_STEPS].zero) begin
         rsp_data_in.row_index = '0;
         rsp_data_in.col_index = '0;
         rsp_data_in.in_grid   = 1'b0;
      end else begin
         rsp_data_in.row_index = row_in;
         rsp_data_in.col_index = col_in;
         rsp_data_in.in_grid   = (row_in >= 0)
                              && (row_in < ppg_pkg::index_type'(ppg_pkg::GRID_ROWS))
                              && (col_in >= 0)
                              && (col_in < ppg_pkg::index_type'(ppg_pkg::GRID_COLS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step_valid[ppg_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a held result must block new transactions
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result is stalled");

   a_zero_den_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.row_index == '0 && rsp_data.col_index == '0 && !rsp_data.in_grid)
      else $error("zero denominator result carries nonzero fields");

   a_in_grid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_grid |->
         rsp_data.row_index >= 0 && rsp_data.col_index >= 0
         && rsp_data.row_index < ppg_pkg::index_type'(ppg_pkg::GRID_ROWS)
         && rsp_data.col_index < ppg_pkg::index_type'(ppg_pkg::GRID_COLS))
      else $error("in_grid set for an index outside the grid");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule
